FILE: hw/rtl/mitf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mitf_pkg;

  // Data widths.
  localparam int unsigned TEMP_W     = 24;
  localparam int unsigned COEF_W     = 17;
  localparam int unsigned PROD_W     = TEMP_W + COEF_W;
  localparam int unsigned ACC_W      = PROD_W + 1;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Default converter width.
  localparam int unsigned ADC_BITS_DEF = 12;

  // Filter weights, Q16 with the new and old weights summing to one.
  localparam logic signed [COEF_W-1:0] LP_NEW = 17'sd1311;
  localparam logic signed [COEF_W-1:0] LP_OLD = 17'sd64225;
  localparam logic signed [COEF_W-1:0] DS_NEW = 17'sd3932;
  localparam logic signed [COEF_W-1:0] DS_OLD = 17'sd61604;

  // Rounding bias for the Q16 filters.
  localparam logic signed [ACC_W-1:0] BLEND_BIAS = 42'sd32768;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAST      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd4;

  // Configuration reset values.
  localparam logic signed [23:0] GAIN_RST      = 24'sd5280;
  localparam logic signed [15:0] OFFSET_RST    = 16'sd0;
  localparam logic [7:0]         WARMUP_RST    = 8'd50;
  localparam logic [7:0]         FAST_RST      = 8'd16;
  localparam logic [15:0]        THRESHOLD_RST = 16'd256;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAL,
    ST_HIST,
    ST_SEL,
    ST_LP_A,
    ST_LP_B,
    ST_LP_R,
    ST_DISP,
    ST_DS_A,
    ST_DS_B,
    ST_DS_R,
    ST_DS_CMP,
    ST_FIN
  } state_e;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic mul_en;
    logic acc_load;
  } mac_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/median_iir_temperature_filter_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Temperature filter core. Each accepted item is one converter reading; it is
// calibrated with gain and offset, passed through a three-point median, a
// 0.02/0.98 low-pass filter (pass-through during warm-up) and a display filter
// with fast and stable modes, and one result item is produced per input item.
// All multiplications run through one shared multiplier under a small
// sequencer. The low-pass steps are skipped in warm-up pass-through, the
// display blend steps are skipped in fast mode, and the sequencer goes back
// to idle before the next item is taken. The result sits in an output
// register, so the next item may be accepted while the previous result
// waits. Configuration writes take effect immediately; the user must make
// them while the block is idle, as the block itself does not enforce this.
module median_iir_temperature_filter_core #(
  parameter int unsigned ADC_BITS = mitf_pkg::ADC_BITS_DEF
) (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  input  wire                                        cfg_we_i,
  input  wire logic [mitf_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [mitf_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  wire                                        in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic [ADC_BITS-1:0]                   adc_sample_i,
  output logic                                       out_valid_o,
  input  wire                                        out_stall_i,
  output logic signed [mitf_pkg::TEMP_W-1:0]         display_temp_o,
  output logic signed [mitf_pkg::TEMP_W-1:0]         filtered_temp_o,
  output logic signed [mitf_pkg::TEMP_W-1:0]         median_temp_o,
  output logic                                       stable_mode_o,
  output logic                                       ready_res_o
);

  localparam int unsigned TW = mitf_pkg::TEMP_W;
  localparam int unsigned AW = mitf_pkg::ACC_W;
  localparam int unsigned PW = mitf_pkg::PROD_W;
  localparam int unsigned CW = mitf_pkg::COEF_W;

  // Saturate a wide signed value to the temperature range.
  function automatic logic signed [TW-1:0] sat_temp(input logic signed [34:0] v);
    logic signed [34:0] hi;
    logic signed [34:0] lo;
    hi = 35'sd8388607;
    lo = -35'sd8388608;
    if (v > hi) begin
      sat_temp = 24'sh7FFFFF;
    end else if (v < lo) begin
      sat_temp = 24'sh800000;
    end else begin
      sat_temp = v[TW-1:0];
    end
  endfunction

  // Configuration registers.
  logic signed [23:0] gain_q;
  logic signed [15:0] offset_q;
  logic [7:0]         warmup_len_q;
  logic [7:0]         fast_len_q;
  logic [15:0]        threshold_q;

  // Filter state.
  mitf_pkg::state_e   state_q, state_d;
  logic [ADC_BITS-1:0] adc_q;
  logic signed [TW-1:0] hist_q [3];
  logic [1:0]         hist_ptr_q;
  logic [7:0]         warmup_cnt_q;
  logic signed [TW-1:0] lowpass_q;
  logic signed [TW-1:0] display_q;
  logic [7:0]         fast_cnt_q;
  logic               stable_q;
  logic               warmed_q;
  logic signed [TW-1:0] med_q;
  logic               out_valid_q;

  // Shared unit connections.
  mitf_pkg::mac_ctrl_t  mac_ctrl;
  logic signed [TW-1:0] op_a;
  logic signed [CW-1:0] op_b;
  logic signed [PW-1:0] mac_prod;
  logic signed [AW-1:0] mac_sum;

  mitf_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (mac_prod),
    .sum_o  (mac_sum)
  );

  logic in_accept;
  logic out_free;
  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  // Calibration: round the gain product to 1/256 degree, add the offset.
  logic signed [AW-1:0] cal_round;
  logic signed [34:0]   cal_sum;
  logic signed [TW-1:0] cal_temp;
  assign cal_round = {mac_prod[PW-1], mac_prod} + 42'sd128;
  assign cal_sum   = {cal_round[AW-1], cal_round[AW-1:8]}
                   + {{19{offset_q[15]}}, offset_q};
  assign cal_temp  = sat_temp(cal_sum);

  // Blend result: round the Q16 sum and saturate.
  logic signed [TW-1:0] blend_temp;
  assign blend_temp = sat_temp({{9{mac_sum[AW-1]}}, mac_sum[AW-1:16]});

  // Median of the three history entries, taken by value.
  logic signed [TW-1:0] med_lo, med_hi, med_val;
  always_comb begin
    med_lo = (hist_q[0] < hist_q[1]) ? hist_q[0] : hist_q[1];
    med_hi = (hist_q[0] < hist_q[1]) ? hist_q[1] : hist_q[0];
    if (hist_q[2] <= med_lo) begin
      med_val = med_lo;
    end else if (hist_q[2] >= med_hi) begin
      med_val = med_hi;
    end else begin
      med_val = hist_q[2];
    end
  end

  // The low-pass filter is bypassed while warm-up is still running.
  logic passthrough;
  assign passthrough = !warmed_q && (warmup_cnt_q < warmup_len_q);

  // Fast-mode count and the switch to stable mode.
  logic [7:0] fast_cnt_inc;
  assign fast_cnt_inc = fast_cnt_q + 8'd1;

  // Distance between display and low-pass values.
  logic signed [TW:0] diff;
  logic [TW:0]        diff_abs;
  assign diff     = {display_q[TW-1], display_q} - {lowpass_q[TW-1], lowpass_q};
  assign diff_abs = diff[TW] ? (~diff + 25'd1) : diff;

  // Configuration write port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q       <= mitf_pkg::GAIN_RST;
      offset_q     <= mitf_pkg::OFFSET_RST;
      warmup_len_q <= mitf_pkg::WARMUP_RST;
      fast_len_q   <= mitf_pkg::FAST_RST;
      threshold_q  <= mitf_pkg::THRESHOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mitf_pkg::REG_GAIN:      gain_q       <= cfg_data_i;
        mitf_pkg::REG_OFFSET:    offset_q     <= cfg_data_i[15:0];
        mitf_pkg::REG_WARMUP:    warmup_len_q <= cfg_data_i[7:0];
        mitf_pkg::REG_FAST:      fast_len_q   <= cfg_data_i[7:0];
        mitf_pkg::REG_THRESHOLD: threshold_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mitf_pkg::ST_IDLE:   if (in_valid_i) state_d = mitf_pkg::ST_CAL;
      mitf_pkg::ST_CAL:    state_d = mitf_pkg::ST_HIST;
      mitf_pkg::ST_HIST:   state_d = mitf_pkg::ST_SEL;
      mitf_pkg::ST_SEL:    state_d = passthrough ? mitf_pkg::ST_DISP : mitf_pkg::ST_LP_A;
      mitf_pkg::ST_LP_A:   state_d = mitf_pkg::ST_LP_B;
      mitf_pkg::ST_LP_B:   state_d = mitf_pkg::ST_LP_R;
      mitf_pkg::ST_LP_R:   state_d = mitf_pkg::ST_DISP;
      mitf_pkg::ST_DISP:   state_d = stable_q ? mitf_pkg::ST_DS_A : mitf_pkg::ST_FIN;
      mitf_pkg::ST_DS_A:   state_d = mitf_pkg::ST_DS_B;
      mitf_pkg::ST_DS_B:   state_d = mitf_pkg::ST_DS_R;
      mitf_pkg::ST_DS_R:   state_d = mitf_pkg::ST_DS_CMP;
      mitf_pkg::ST_DS_CMP: state_d = mitf_pkg::ST_FIN;
      mitf_pkg::ST_FIN:    if (out_free) state_d = mitf_pkg::ST_IDLE;
      default:             state_d = mitf_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: operands and control of the shared unit.
  always_comb begin
    mac_ctrl = '0;
    op_a     = gain_q;
    op_b     = {{(CW - ADC_BITS){1'b0}}, adc_q};
    in_stall_o = (state_q != mitf_pkg::ST_IDLE);
    case (state_q)
      mitf_pkg::ST_CAL: begin
        mac_ctrl.mul_en = 1'b1;
      end
      mitf_pkg::ST_LP_A: begin
        mac_ctrl.mul_en = 1'b1;
        op_a = med_q;
        op_b = mitf_pkg::LP_NEW;
      end
      mitf_pkg::ST_LP_B: begin
        mac_ctrl.mul_en   = 1'b1;
        mac_ctrl.acc_load = 1'b1;
        op_a = lowpass_q;
        op_b = mitf_pkg::LP_OLD;
      end
      mitf_pkg::ST_DS_A: begin
        mac_ctrl.mul_en = 1'b1;
        op_a = lowpass_q;
        op_b = mitf_pkg::DS_NEW;
      end
      mitf_pkg::ST_DS_B: begin
        mac_ctrl.mul_en   = 1'b1;
        mac_ctrl.acc_load = 1'b1;
        op_a = display_q;
        op_b = mitf_pkg::DS_OLD;
      end
      default: ;
    endcase
  end

  // Control and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mitf_pkg::ST_IDLE;
      hist_q[0]    <= '0;
      hist_q[1]    <= '0;
      hist_q[2]    <= '0;
      hist_ptr_q   <= '0;
      warmup_cnt_q <= '0;
      lowpass_q    <= '0;
      display_q    <= '0;
      fast_cnt_q   <= '0;
      stable_q     <= 1'b0;
      warmed_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      // A finished item fills the output register once it is empty or the old result leaves.
      if (state_q == mitf_pkg::ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        mitf_pkg::ST_HIST: begin
          for (int i = 0; i < 3; i++) begin
            if (hist_ptr_q == 2'(i)) begin
              hist_q[i] <= cal_temp;
            end
          end
          hist_ptr_q <= (hist_ptr_q >= 2'd2) ? 2'd0 : hist_ptr_q + 2'd1;
        end
        mitf_pkg::ST_SEL: begin
          if (passthrough) begin
            warmup_cnt_q <= warmup_cnt_q + 8'd1;
            lowpass_q    <= med_val;
          end
        end
        mitf_pkg::ST_LP_R: begin
          lowpass_q <= blend_temp;
          warmed_q  <= 1'b1;
        end
        mitf_pkg::ST_DISP: begin
          if (!stable_q && warmed_q) begin
            display_q <= lowpass_q;
            if (fast_cnt_inc >= fast_len_q) begin
              fast_cnt_q <= '0;
              stable_q   <= 1'b1;
            end else begin
              fast_cnt_q <= fast_cnt_inc;
            end
          end
        end
        mitf_pkg::ST_DS_R: begin
          display_q <= blend_temp;
        end
        mitf_pkg::ST_DS_CMP: begin
          if (diff_abs > {9'd0, threshold_q}) begin
            stable_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Item payload and result registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      adc_q <= adc_sample_i;
    end
    if (state_q == mitf_pkg::ST_SEL) begin
      med_q <= med_val;
    end
    if (state_q == mitf_pkg::ST_FIN && out_free) begin
      display_temp_o  <= display_q;
      filtered_temp_o <= lowpass_q;
      median_temp_o   <= med_q;
      stable_mode_o   <= stable_q;
      ready_res_o     <= warmed_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // A new result appears only when the sequencer finishes an item.
  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == mitf_pkg::ST_FIN))
    else $error("result raised outside the finish step");

  // An accepted item always starts with the calibration multiply.
  a_accept_starts_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == mitf_pkg::ST_CAL)
    else $error("accepted item did not start calibration");

  // The history pointer stays within the three-entry ring.
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_ptr_q != 2'd3)
    else $error("history pointer out of range");

  // Stable display mode is reached only after warm-up has ended.
  a_stable_needs_warm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stable_q |-> warmed_q)
    else $error("stable mode without warm-up");

endmodule

`default_nettype wire

FILE: hw/rtl/mitf_mac.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared multiplier with a product register and a one-term accumulator.
// A two-term blend loads the first product plus the rounding bias, and the
// sum output then adds the second product.
module mitf_mac (
  input  wire                                        clk_i,
  input  wire mitf_pkg::mac_ctrl_t                   ctrl_i,
  input  wire logic signed [mitf_pkg::TEMP_W-1:0]    op_a_i,
  input  wire logic signed [mitf_pkg::COEF_W-1:0]    op_b_i,
  output logic signed [mitf_pkg::PROD_W-1:0]         prod_o,
  output logic signed [mitf_pkg::ACC_W-1:0]          sum_o
);

  logic signed [mitf_pkg::PROD_W-1:0] prod_q;
  logic signed [mitf_pkg::ACC_W-1:0]  acc_q;
  logic signed [mitf_pkg::ACC_W-1:0]  prod_ext;

  assign prod_ext = {prod_q[mitf_pkg::PROD_W-1], prod_q};

  // Product register, then the accumulator, which loads from the registered product.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= op_a_i * op_b_i;
    end
    if (ctrl_i.acc_load) begin
      acc_q <= prod_ext + mitf_pkg::BLEND_BIAS;
    end
  end

  assign prod_o = prod_q;
  assign sum_o  = acc_q + prod_ext;

endmodule

`default_nettype wire
